### hw/rtl/bm25f_pkg.sv
// Shared types and constants for the BM25F term scorer.
`default_nettype none

package bm25f_pkg;

    // status reported with each score
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_ZERO_DIV = 2'd2,
        ST_ZERO_QTF = 2'd3
    } status_t;

    // configuration register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_K1     = 3'd0,
        REG_K3     = 3'd1,
        REG_SUM_W  = 3'd2,
        REG_DESC_W = 3'd3,
        REG_SUM_B  = 3'd4,
        REG_DESC_B = 3'd5,
        REG_SUM_A  = 3'd6,
        REG_DESC_A = 3'd7
    } reg_idx_t;

    localparam logic [16:0] B_ONE = 17'd65536;  // b = 1.0 in Q1.16
    localparam int FDW = 41;                    // field length divisor width
    localparam int FQW = 48;                    // field value quotient width

endpackage

`default_nettype wire

### hw/rtl/bm25f_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
`default_nettype none

module bm25f_div #(
    parameter int DW = 41,
    parameter int QW = 48,
    parameter int TW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_rem,   // must be below in_den
    input  wire logic [QW-1:0] in_num,   // low dividend bits, MSB first
    input  wire logic [DW-1:0] in_den,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [QW-1:0]      out_quot,
    output logic [TW-1:0]      out_tag
);

    logic          v_reg [QW];
    logic [DW-1:0] r_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [QW-1:0] n_reg [QW];
    logic [QW-1:0] q_reg [QW];
    logic [TW-1:0] t_reg [QW];

    genvar k;
    for (k = 0; k < QW; k++)
    begin : g_stage
        logic          v_prev;
        logic [DW-1:0] r_prev;
        logic [DW-1:0] d_prev;
        logic [QW-1:0] n_prev;
        logic [QW-1:0] q_prev;
        logic [TW-1:0] t_prev;
        logic [DW:0]   r_shift;
        logic [DW:0]   r_diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign v_prev = in_valid;
            assign r_prev = in_rem;
            assign d_prev = in_den;
            assign n_prev = in_num;
            assign q_prev = '0;
            assign t_prev = in_tag;
        end
        else
        begin : g_rest
            assign v_prev = v_reg[k-1];
            assign r_prev = r_reg[k-1];
            assign d_prev = d_reg[k-1];
            assign n_prev = n_reg[k-1];
            assign q_prev = q_reg[k-1];
            assign t_prev = t_reg[k-1];
        end

        assign r_shift = {r_prev, n_prev[QW-1]};
        assign r_diff  = r_shift - {1'b0, d_prev};
        assign ge      = (r_shift >= {1'b0, d_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? r_diff[DW-1:0] : r_shift[DW-1:0];
                d_reg[k] <= d_prev;
                n_reg[k] <= {n_prev[QW-2:0], 1'b0};
                q_reg[k] <= {q_prev[QW-2:0], ge};
                t_reg[k] <= t_prev;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_quot  = q_reg[QW-1];
    assign out_tag   = t_reg[QW-1];

endmodule

`default_nettype wire

### hw/rtl/bm25f_field.sv
// Length normalisation front end of one field: divisor, scaled numerator, flags.
`default_nettype none

module bm25f_field #(
    parameter int TF_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [TF_BITS-1:0]          tf,
    input  wire logic [15:0]                 len,
    input  wire logic [15:0]                 w,
    input  wire logic [16:0]                 b,
    input  wire logic [23:0]                 avg,
    output logic [bm25f_pkg::FDW-1:0]        rem,
    output logic [bm25f_pkg::FQW-1:0]        num,
    output logic [bm25f_pkg::FDW-1:0]        den,
    output logic                             ovf,
    output logic                             tfz,
    output logic                             bad
);

    localparam int FDW = bm25f_pkg::FDW;
    localparam int FQW = bm25f_pkg::FQW;
    localparam int WTW = 16 + TF_BITS;
    localparam int NW  = TF_BITS + 40;
    localparam int HW  = (TF_BITS + 16 > FDW) ? TF_BITS + 16 : FDW;

    logic [16:0]     bsat;
    logic [FDW-1:0]  a1_reg;
    logic [32:0]     bl1_reg;
    logic [WTW-1:0]  wt1_reg;
    logic            tfz1_reg;
    logic [FDW-1:0]  d2_reg;
    logic [NW-1:0]   n2_reg;
    logic            tfz2_reg;
    logic [HW-1:0]   nh;
    logic [FDW-1:0]  rem_reg;
    logic [FQW-1:0]  num_reg;
    logic [FDW-1:0]  den_reg;
    logic            ovf_reg;
    logic            tfz_reg;
    logic            bad_reg;

    assign bsat = (b > bm25f_pkg::B_ONE) ? bm25f_pkg::B_ONE : b;
    assign nh   = HW'(n2_reg >> 24);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: the three products
            a1_reg   <= FDW'(bm25f_pkg::B_ONE - bsat) * FDW'(avg);
            bl1_reg  <= 33'(bsat) * 33'(len);
            wt1_reg  <= WTW'(w) * WTW'(tf);
            tfz1_reg <= (tf == '0);
            // stage 2: divisor and numerator w*tf*avg
            d2_reg   <= a1_reg + {bl1_reg, 8'b0};
            n2_reg   <= NW'(wt1_reg) * NW'(avg);
            tfz2_reg <= tfz1_reg;
            // stage 3: quotient overflow test; dividend is n * 2^24
            ovf_reg  <= (nh >= HW'(d2_reg));
            rem_reg  <= nh[FDW-1:0];
            num_reg  <= {n2_reg[23:0], 24'b0};
            den_reg  <= d2_reg;
            tfz_reg  <= tfz2_reg;
            bad_reg  <= !tfz2_reg && ((avg == '0) || (d2_reg == '0));
        end
    end

    assign rem = rem_reg;
    assign num = num_reg;
    assign den = den_reg;
    assign ovf = ovf_reg;
    assign tfz = tfz_reg;
    assign bad = bad_reg;

endmodule

`default_nettype wire

### hw/rtl/bm25f_term_score.sv
// Top level of the BM25F two-field term scorer.
//
// channel | dir | fields
// --------+-----+-------------------------------------------------------------
// s_*     | in  | idf_value, sum_tf, desc_tf, sum_len, desc_len,
//         |     | qry_sum_tf, qry_desc_tf
// m_*     | out | score (tdata), status (tuser)
// APB     | in  | eight config registers at byte address 4*i
//
// One request enters per cycle unless the output stalls. The path holds three
// bit-per-stage dividers (48 field bits, 17 term bits, 21 query weight bits).
// Reset clears valid bits and loads the config defaults.
// All stages advance together; they hold while a result waits and m_tready
// is low, so nothing is dropped or repeated.
`default_nettype none

module bm25f_term_score #(
    parameter int TF_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // idf_value[24], sum_tf[TF], desc_tf[TF], sum_len[16],
    // desc_len[16], qry_sum_tf[TF], qry_desc_tf[TF], zero pad
    input  wire logic [((56 + 4*TF_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // score[32]
    output logic [31:0]      m_tdata,
    // status[2]
    output logic [1:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int TF   = TF_BITS;
    localparam int FDW  = bm25f_pkg::FDW;
    localparam int FQW  = bm25f_pkg::FQW;
    localparam int QP_W = TF + 17;
    localparam int QN_W = TF + 34;
    localparam int QD_W = TF + 22;
    localparam int T_W  = 49;
    localparam int TDW  = 50;
    localparam int TQW  = 17;
    localparam int QQW  = 21;
    localparam int IT_W = 41;
    localparam int SW   = 24 + QP_W + 4;
    localparam int TTW  = 24 + QN_W + QD_W + 3;
    localparam int QTW  = IT_W + 3;

    // config registers
    logic [15:0] k1_reg, k3_reg, sw_reg, dw_reg;
    logic [16:0] sb_reg, db_reg;
    logic [23:0] sa_reg, da_reg;
    logic        wr;

    logic en;

    // input stage
    logic          p0_v_reg;
    logic [23:0]   p0_idf_reg;
    logic [TF-1:0] p0_stf_reg, p0_dtf_reg, p0_qs_reg, p0_qd_reg;
    logic [15:0]   p0_sl_reg, p0_dl_reg;

    // side path alongside the field front ends
    logic            f1_v_reg, f2_v_reg, f3_v_reg;
    logic [23:0]     f1_idf_reg, f2_idf_reg, f3_idf_reg;
    logic            f1_abs_reg, f2_abs_reg, f3_abs_reg;
    logic [TF+15:0]  f1_sq_reg, f1_dq_reg;
    logic [QP_W-1:0] f2_q_reg, f3_q_reg;

    logic [FDW-1:0] s_rem, s_den, d_rem, d_den;
    logic [FQW-1:0] s_num, d_num;
    logic           s_ovf, s_tfz, s_bad, d_ovf, d_tfz, d_bad;

    // field dividers
    logic            fs_v;
    logic [FQW-1:0]  fs_q, fd_q;
    logic [SW-1:0]   fs_tag;
    logic [2:0]      fd_tag;
    logic [23:0]     fs_idf;
    logic [QP_W-1:0] fs_qv;
    logic            fs_abs, fs_ovf, fs_tfz, fs_bad, fd_ovf, fd_tfz, fd_bad;
    logic [FQW-1:0]  fv_s, fv_d;

    logic            g1_v_reg, g2_v_reg;
    logic [23:0]     g1_idf_reg, g2_idf_reg;
    logic [T_W-1:0]  g1_t_reg, g2_t_reg;
    logic            g1_abs_reg, g2_abs_reg, g1_bad_reg, g2_bad_reg;
    logic            g1_q3_reg, g2_q3_reg;
    logic [QN_W-1:0] g1_qn_reg, g2_qn_reg;
    logic [QD_W-1:0] g1_qd_reg, g2_qd_reg;
    logic [TDW-1:0]  g2_kt_reg;

    // term divider
    logic            td_v;
    logic [TQW-1:0]  td_q;
    logic [TTW-1:0]  td_tag;
    logic [23:0]     td_idf;
    logic [QN_W-1:0] td_qn;
    logic [QD_W-1:0] td_qd;
    logic            td_abs, td_bad, td_q3;

    logic            h1_v_reg;
    logic [IT_W-1:0] h1_it_reg;
    logic [QN_W-1:0] h1_qn_reg;
    logic [QD_W-1:0] h1_qd_reg;
    logic            h1_abs_reg, h1_bad_reg, h1_q3_reg;

    // query weight divider
    logic            qd_v;
    logic [QQW-1:0]  qd_q;
    logic [QTW-1:0]  qd_tag;
    logic [IT_W-1:0] qd_it;
    logic            qd_abs, qd_bad, qd_q3;
    logic [QQW-1:0]  qw;

    logic            k1_v_reg;
    logic [IT_W+10:0] k1_lo_reg;
    logic [IT_W+9:0]  k1_hi_reg;
    logic            k1_abs_reg, k1_bad_reg, k1_q3_reg;
    logic [61:0]     prod;

    logic                 m_valid_reg;
    logic [31:0]          m_score_reg;
    bm25f_pkg::status_t   m_status_reg;
    bm25f_pkg::status_t   status_next;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= 16'd4915;
            k3_reg <= 16'd0;
            sw_reg <= 16'd256;
            dw_reg <= 16'd256;
            sb_reg <= 17'd49152;
            db_reg <= 17'd49152;
            sa_reg <= 24'd256;
            da_reg <= 24'd256;
        end
        else if (wr)
        begin
            case (bm25f_pkg::reg_idx_t'(paddr[4:2]))
                bm25f_pkg::REG_K1:     k1_reg <= pwdata[15:0];
                bm25f_pkg::REG_K3:     k3_reg <= pwdata[15:0];
                bm25f_pkg::REG_SUM_W:  sw_reg <= pwdata[15:0];
                bm25f_pkg::REG_DESC_W: dw_reg <= pwdata[15:0];
                bm25f_pkg::REG_SUM_B:  sb_reg <= pwdata[16:0];
                bm25f_pkg::REG_DESC_B: db_reg <= pwdata[16:0];
                bm25f_pkg::REG_SUM_A:  sa_reg <= pwdata[23:0];
                bm25f_pkg::REG_DESC_A: da_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (bm25f_pkg::reg_idx_t'(paddr[4:2]))
            bm25f_pkg::REG_K1:     prdata = {16'b0, k1_reg};
            bm25f_pkg::REG_K3:     prdata = {16'b0, k3_reg};
            bm25f_pkg::REG_SUM_W:  prdata = {16'b0, sw_reg};
            bm25f_pkg::REG_DESC_W: prdata = {16'b0, dw_reg};
            bm25f_pkg::REG_SUM_B:  prdata = {15'b0, sb_reg};
            bm25f_pkg::REG_DESC_B: prdata = {15'b0, db_reg};
            bm25f_pkg::REG_SUM_A:  prdata = {8'b0, sa_reg};
            bm25f_pkg::REG_DESC_A: prdata = {8'b0, da_reg};
            default:               prdata = 32'b0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg    <= 1'b0;
            f1_v_reg    <= 1'b0;
            f2_v_reg    <= 1'b0;
            f3_v_reg    <= 1'b0;
            g1_v_reg    <= 1'b0;
            g2_v_reg    <= 1'b0;
            h1_v_reg    <= 1'b0;
            k1_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_v_reg    <= s_tvalid;
            f1_v_reg    <= p0_v_reg;
            f2_v_reg    <= f1_v_reg;
            f3_v_reg    <= f2_v_reg;
            g1_v_reg    <= fs_v;
            g2_v_reg    <= g1_v_reg;
            h1_v_reg    <= td_v;
            k1_v_reg    <= qd_v;
            m_valid_reg <= k1_v_reg;
        end
    end

    // ---------------- input and front end ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_idf_reg <= s_tdata[23:0];
            p0_stf_reg <= s_tdata[24 +: TF];
            p0_dtf_reg <= s_tdata[24 + TF +: TF];
            p0_sl_reg  <= s_tdata[24 + 2*TF +: 16];
            p0_dl_reg  <= s_tdata[40 + 2*TF +: 16];
            p0_qs_reg  <= s_tdata[56 + 2*TF +: TF];
            p0_qd_reg  <= s_tdata[56 + 3*TF +: TF];

            f1_idf_reg <= p0_idf_reg;
            f1_abs_reg <= (p0_stf_reg == '0) && (p0_dtf_reg == '0);
            f1_sq_reg  <= (TF+16)'(sw_reg) * (TF+16)'(p0_qs_reg);
            f1_dq_reg  <= (TF+16)'(dw_reg) * (TF+16)'(p0_qd_reg);

            f2_idf_reg <= f1_idf_reg;
            f2_abs_reg <= f1_abs_reg;
            f2_q_reg   <= QP_W'(f1_sq_reg) + QP_W'(f1_dq_reg);

            f3_idf_reg <= f2_idf_reg;
            f3_abs_reg <= f2_abs_reg;
            f3_q_reg   <= f2_q_reg;
        end
    end

    bm25f_field #(.TF_BITS(TF_BITS)) u_field_sum (
        .clk (clk),
        .en  (en),
        .tf  (p0_stf_reg),
        .len (p0_sl_reg),
        .w   (sw_reg),
        .b   (sb_reg),
        .avg (sa_reg),
        .rem (s_rem),
        .num (s_num),
        .den (s_den),
        .ovf (s_ovf),
        .tfz (s_tfz),
        .bad (s_bad)
    );

    bm25f_field #(.TF_BITS(TF_BITS)) u_field_desc (
        .clk (clk),
        .en  (en),
        .tf  (p0_dtf_reg),
        .len (p0_dl_reg),
        .w   (dw_reg),
        .b   (db_reg),
        .avg (da_reg),
        .rem (d_rem),
        .num (d_num),
        .den (d_den),
        .ovf (d_ovf),
        .tfz (d_tfz),
        .bad (d_bad)
    );

    bm25f_div #(.DW(FDW), .QW(FQW), .TW(SW)) u_div_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f3_v_reg),
        .in_rem    (s_rem),
        .in_num    (s_num),
        .in_den    (s_den),
        .in_tag    ({f3_idf_reg, f3_q_reg, f3_abs_reg, s_ovf, s_tfz, s_bad}),
        .out_valid (fs_v),
        .out_quot  (fs_q),
        .out_tag   (fs_tag)
    );

    bm25f_div #(.DW(FDW), .QW(FQW), .TW(3)) u_div_desc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f3_v_reg),
        .in_rem    (d_rem),
        .in_num    (d_num),
        .in_den    (d_den),
        .in_tag    ({d_ovf, d_tfz, d_bad}),
        .out_valid (),
        .out_quot  (fd_q),
        .out_tag   (fd_tag)
    );

    assign {fs_idf, fs_qv, fs_abs, fs_ovf, fs_tfz, fs_bad} = fs_tag;
    assign {fd_ovf, fd_tfz, fd_bad} = fd_tag;

    // field value saturates at 2^48-1; zero tf gives zero
    assign fv_s = fs_tfz ? '0 : (fs_ovf ? '1 : fs_q);
    assign fv_d = fd_tfz ? '0 : (fd_ovf ? '1 : fd_q);

    // ---------------- sum, k1 divisor, query weight operands ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_idf_reg <= fs_idf;
            g1_t_reg   <= T_W'(fv_s) + T_W'(fv_d);
            g1_abs_reg <= fs_abs;
            g1_bad_reg <= fs_bad || fd_bad;
            g1_q3_reg  <= (k3_reg != '0) && (fs_qv == '0);
            g1_qn_reg  <= QN_W'({1'b0, k3_reg} + 17'd4096) * QN_W'(fs_qv);
            g1_qd_reg  <= QD_W'(k3_reg) + QD_W'({fs_qv, 4'b0});

            g2_idf_reg <= g1_idf_reg;
            g2_t_reg   <= g1_t_reg;
            g2_kt_reg  <= TDW'({k1_reg, 4'b0}) + TDW'(g1_t_reg);
            g2_abs_reg <= g1_abs_reg;
            g2_bad_reg <= g1_bad_reg;
            g2_q3_reg  <= g1_q3_reg;
            g2_qn_reg  <= g1_qn_reg;
            g2_qd_reg  <= g1_qd_reg;
        end
    end

    // term = t*2^16 / (k1*16 + t); quotient fits 17 bits since t <= kt
    bm25f_div #(.DW(TDW), .QW(TQW), .TW(TTW)) u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g2_v_reg),
        .in_rem    (TDW'(g2_t_reg >> 1)),
        .in_num    ({g2_t_reg[0], 16'b0}),
        .in_den    (g2_kt_reg),
        .in_tag    ({g2_idf_reg, g2_qn_reg, g2_qd_reg, g2_abs_reg,
                     g2_bad_reg || (g2_kt_reg == '0), g2_q3_reg}),
        .out_valid (td_v),
        .out_quot  (td_q),
        .out_tag   (td_tag)
    );

    assign {td_idf, td_qn, td_qd, td_abs, td_bad, td_q3} = td_tag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_it_reg  <= IT_W'(td_idf) * IT_W'(td_q);
            h1_qn_reg  <= td_qn;
            h1_qd_reg  <= td_qd;
            h1_abs_reg <= td_abs;
            h1_bad_reg <= td_bad;
            h1_q3_reg  <= td_q3;
        end
    end

    // query weight = (k3+4096)*q*256 / (k3 + 16q); stays below 2^21
    bm25f_div #(.DW(QD_W), .QW(QQW), .TW(QTW)) u_div_query (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h1_v_reg),
        .in_rem    (QD_W'(h1_qn_reg >> 13)),
        .in_num    ({h1_qn_reg[12:0], 8'b0}),
        .in_den    (h1_qd_reg),
        .in_tag    ({h1_it_reg, h1_abs_reg, h1_bad_reg, h1_q3_reg}),
        .out_valid (qd_v),
        .out_quot  (qd_q),
        .out_tag   (qd_tag)
    );

    assign {qd_it, qd_abs, qd_bad, qd_q3} = qd_tag;
    assign qw = (k3_reg == '0) ? QQW'(65536) : qd_q;

    // ---------------- final product, split over two partial products ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_lo_reg  <= (IT_W+11)'(qd_it) * (IT_W+11)'(qw[10:0]);
            k1_hi_reg  <= (IT_W+10)'(qd_it) * (IT_W+10)'(qw[20:11]);
            k1_abs_reg <= qd_abs;
            k1_bad_reg <= qd_bad;
            k1_q3_reg  <= qd_q3;
        end
    end

    assign prod = 62'(k1_lo_reg) + {k1_hi_reg, 11'b0};

    always_comb
    begin
        if (k1_abs_reg)
        begin
            status_next = bm25f_pkg::ST_ABSENT;
        end
        else if (k1_bad_reg)
        begin
            status_next = bm25f_pkg::ST_ZERO_DIV;
        end
        else if (k1_q3_reg)
        begin
            status_next = bm25f_pkg::ST_ZERO_QTF;
        end
        else
        begin
            status_next = bm25f_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_status_reg <= status_next;
            m_score_reg  <= (status_next == bm25f_pkg::ST_OK) ? 32'(prod[61:32]) : 32'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_score_reg;
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

### tb/bm25f_term_score_tb.sv
// Self-checking testbench for the BM25F two-field term scorer.
`default_nettype none

module bm25f_term_score_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TF_BITS = 16;
    localparam int DW = ((56 + 4*TF_BITS + 7) / 8) * 8;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [23:0] idf;
        logic [15:0] stf;
        logic [15:0] dtf;
        logic [15:0] slen;
        logic [15:0] dlen;
        logic [15:0] qs;
        logic [15:0] qd;
    } term_req_t;

    typedef struct packed {
        logic [31:0]        score;
        bm25f_pkg::status_t status;
    } term_score_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [DW-1:0] s_tdata;
    logic [31:0] m_tdata;
    logic [1:0] m_tuser;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    bm25f_term_score #(.TF_BITS(TF_BITS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the registers
    logic [15:0] k1, k3, sw, dw;
    logic [16:0] sb, db;
    logic [23:0] sa, da;

    term_score_t expected_scores[$];
    int errors, n_items, n_results, send_idle, recv_idle;
    longint cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // min(floor(a*b/d), cap)
    function automatic logic [63:0] scaled_div(logic [127:0] a, logic [127:0] b,
                                               logic [127:0] d, logic [63:0] cap);
        logic [127:0] q;
        q = (a * b) / d;
        return (q > 128'(cap)) ? cap : q[63:0];
    endfunction

    function automatic logic [63:0] field_norm(logic [15:0] tf, logic [15:0] w,
                                               logic [16:0] b, logic [15:0] len,
                                               logic [23:0] avg, inout logic bad);
        logic [63:0] bb, d;
        if (tf == 0)
            return '0;
        bb = (b > 17'd65536) ? 64'd65536 : 64'(b);
        if (avg == 0)
        begin
            bad = 1'b1;
            return '0;
        end
        d = (64'd65536 - bb) * 64'(avg) + bb * 64'(len) * 64'd256;
        if (d == 0)
        begin
            bad = 1'b1;
            return '0;
        end
        return scaled_div(128'(w) * 128'(tf), 128'(avg) << 24, 128'(d),
                          64'hFFFF_FFFF_FFFF);
    endfunction

    function automatic term_score_t predict_score(term_req_t r);
        term_score_t res;
        logic bad;
        logic [63:0] t, kt, term, qw, q12;
        bad = 1'b0;
        res.score = '0;
        if (r.stf == 0 && r.dtf == 0)
        begin
            res.status = bm25f_pkg::ST_ABSENT;
            return res;
        end
        t = field_norm(r.stf, sw, sb, r.slen, sa, bad);
        t += field_norm(r.dtf, dw, db, r.dlen, da, bad);
        kt = (64'(k1) << 4) + t;
        if (bad || kt == 0)
        begin
            res.status = bm25f_pkg::ST_ZERO_DIV;
            return res;
        end
        term = scaled_div(128'(t), 128'd65536, 128'(kt), 64'd65536);
        if (k3 == 0)
            qw = 64'd65536;
        else
        begin
            q12 = (64'(sw) * 64'(r.qs) + 64'(dw) * 64'(r.qd)) << 4;
            if (q12 == 0)
            begin
                res.status = bm25f_pkg::ST_ZERO_QTF;
                return res;
            end
            qw = scaled_div(128'(k3) + 128'd4096, 128'(q12) << 4,
                            128'(k3) + 128'(q12), 64'hFFFF_FFFF);
        end
        res.score = 32'(scaled_div(128'(r.idf) * 128'(term), 128'(qw), 128'(1) << 32,
                                   64'hFFFF_FFFF));
        res.status = bm25f_pkg::ST_OK;
        return res;
    endfunction

    task automatic apb_write(bm25f_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            bm25f_pkg::REG_K1:     k1 = val[15:0];
            bm25f_pkg::REG_K3:     k3 = val[15:0];
            bm25f_pkg::REG_SUM_W:  sw = val[15:0];
            bm25f_pkg::REG_DESC_W: dw = val[15:0];
            bm25f_pkg::REG_SUM_B:  sb = val[16:0];
            bm25f_pkg::REG_DESC_B: db = val[16:0];
            bm25f_pkg::REG_SUM_A:  sa = val[23:0];
            default:               da = val[23:0];
        endcase
    endtask

    // tvalid stays high after the accepting edge; the next call or drain() decides
    task automatic send_term(term_req_t r);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= DW'({r.qd, r.qs, r.dlen, r.slen, r.dtf, r.stf, r.idf});
        expected_scores.push_back(predict_score(r));
        n_items++;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic term_req_t rand_term();
        term_req_t r;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        r = raw[119:0];
        case ($urandom_range(7))
            0: r.stf = 0;
            1: r.dtf = 0;
            2: begin r.stf = 16'($urandom_range(20)); r.dtf = 16'($urandom_range(20)); end
            3: begin r.qs = 0; r.qd = 0; end
            4: begin r.slen = 16'($urandom_range(300)); r.dlen = 16'($urandom_range(300)); end
            default: ;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        term_score_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (expected_scores.size() == 0)
            begin
                $display("%0t: unexpected result score=%h status=%0d", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = expected_scores.pop_front();
                if (m_tdata !== want.score)
                begin
                    $display("%0t: score expected %h actual %h", $time, want.score, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        term_req_t r;
        r = '0;
        send_term(r);                               // term absent
        r.stf = 1; r.slen = 0; r.idf = 24'hFFFFFF;
        send_term(r);
        r = '1;
        send_term(r);
        r.dtf = 0; r.slen = 0;
        send_term(r);
        r = '1; r.stf = 0; r.dlen = 100;
        send_term(r);
        r = '1; r.qs = 0; r.qd = 0;
        send_term(r);
        drain();
        // b = 1.0 with zero length: zero divisor
        apb_write(bm25f_pkg::REG_SUM_B, 32'd65536);
        r = '0; r.stf = 3; r.idf = 24'h010000; r.qs = 1;
        send_term(r);
        drain();
        apb_write(bm25f_pkg::REG_SUM_B, 32'h1FFFF);  // above 1.0, saturates
        send_term(r);
        r.slen = 16'hFFFF;
        send_term(r);
        drain();
        apb_write(bm25f_pkg::REG_SUM_A, 0);          // zero average
        send_term(r);
        r.stf = 0; r.dtf = 5;
        send_term(r);
        drain();
        apb_write(bm25f_pkg::REG_K3, 32'hFFFF);      // query weight active
        r = '1; r.qs = 0; r.qd = 0; r.stf = 0;
        send_term(r);                                // zero query tf
        r.qd = 1;
        send_term(r);
        r.qs = 16'hFFFF; r.qd = 16'hFFFF;
        send_term(r);
        drain();
        apb_write(bm25f_pkg::REG_K1, 0);
        apb_write(bm25f_pkg::REG_DESC_W, 0);
        r = '0; r.dtf = 7; r.qs = 2; r.idf = 24'hFFFFFF;
        send_term(r);                                // k1*16+t zero
        drain();
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_term(rand_term());
    endtask

    task automatic test_random_configs();
        for (int ph = 0; ph < 8; ph++)
        begin
            apb_write(bm25f_pkg::REG_K1, (ph == 1) ? 32'hFFFF : $urandom_range(8000));
            apb_write(bm25f_pkg::REG_K3,
                      (ph % 3 == 0) ? 0 : ((ph == 2) ? 32'hFFFF : $urandom));
            apb_write(bm25f_pkg::REG_SUM_W, (ph == 3) ? 32'hFFFF : $urandom_range(1024));
            apb_write(bm25f_pkg::REG_DESC_W, (ph == 4) ? 0 : $urandom_range(1024));
            apb_write(bm25f_pkg::REG_SUM_B, (ph == 5) ? 0 : $urandom_range(65536));
            apb_write(bm25f_pkg::REG_DESC_B,
                      (ph == 6) ? 32'd65536 : $urandom_range(65536));
            apb_write(bm25f_pkg::REG_SUM_A,
                      (ph == 7) ? 32'hFFFFFF : $urandom_range(1, 65535));
            apb_write(bm25f_pkg::REG_DESC_A, (ph == 2) ? 1 : $urandom);
            send_idle = (ph < 3) ? 6 : (ph < 6 ? 46 : 0);
            recv_idle = (ph < 3) ? 46 : (ph < 6 ? 6 : 0);
            random_phase(100);
            drain();                                  // sender waits for all results
            random_phase(100);
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0; clk = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; n_items = 0; n_results = 0; cycles = 0;
        send_idle = 6; recv_idle = 46;
        k1 = 4915; k3 = 0; sw = 256; dw = 256; sb = 49152; db = 49152; sa = 256; da = 256;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_configs();
        $display("covered %0d term requests, %0d results, over 8 register settings",
                 n_items, n_results);
        if (errors == 0 && expected_scores.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
